FILE: rtl/elhp_pkg.sv
// ----------------------------------------------------------------------------
// elhp_pkg
// shared types and constants of the layer-2 header parser
// ----------------------------------------------------------------------------
package elhp_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_IPV4    = 3'd0,
        ST_IPV6    = 3'd1,
        ST_TOOMANY = 3'd2,
        ST_UNSUPP  = 3'd3,
        ST_NOIP    = 3'd4,
        ST_TRUNC   = 3'd5
    } t_status;

    // configuration register indexes
    localparam logic CFG_HEADER_LIMIT = 1'b0;
    localparam logic CFG_LABEL_LIMIT  = 1'b1;

    localparam logic [7:0] HEADER_LIMIT_RST = 8'd64;
    localparam logic [7:0] LABEL_LIMIT_RST  = 8'd128;

    // ethertypes
    localparam logic [15:0] ET_IPV4   = 16'h0800;
    localparam logic [15:0] ET_IPV6   = 16'h86DD;
    localparam logic [15:0] ET_VLAN   = 16'h8100;
    localparam logic [15:0] ET_QINQ1  = 16'h9100;
    localparam logic [15:0] ET_QINQ2  = 16'h9200;
    localparam logic [15:0] ET_QINQ3  = 16'h9300;
    localparam logic [15:0] ET_MPLS_U = 16'h8847;
    localparam logic [15:0] ET_MPLS_M = 16'h8848;

    localparam logic [3:0]  MAC_BYTES  = 4'd12;
    localparam logic [3:0]  TYPE_BYTES = 4'd2;
    localparam logic [3:0]  WORD_BYTES = 4'd4;
    localparam logic [8:0]  L2_BASE    = 9'd14;
    localparam logic [8:0]  WORD_STEP  = 9'd4;
    localparam logic [13:0] LEN_SAT    = 14'h3FFF;

    // one parse result
    typedef struct packed {
        t_status     status;
        logic [7:0]  l3_offset;
        logic [13:0] l3_length;
        logic [1:0]  tag_count;
        logic [11:0] outer_vlan_id;
        logic [11:0] inner_vlan_id;
        logic [15:0] outer_tag_type;
        logic [15:0] inner_tag_type;
    } t_result;

    // limits from the configuration registers
    typedef struct packed {
        logic [7:0] header_limit;
        logic [7:0] label_limit;
    } t_cfg;

endpackage

FILE: rtl/elhp_core.sv
// ----------------------------------------------------------------------------
// elhp_core
// per-frame parse state and the one-byte next-state logic
// ----------------------------------------------------------------------------
module elhp_core #(
    parameter int MAX_FRAME_BYTES = 16384,
    parameter int MAX_TAGS        = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  elhp_pkg::t_cfg   i_cfg,
    output logic             o_result_valid,
    output elhp_pkg::t_result o_result
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int DW = (PW > 15) ? PW + 1 : 16;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES);

    typedef enum logic [2:0] {
        PH_MAC,
        PH_TYPE,
        PH_TAG,
        PH_LABEL,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase            phase;
        elhp_pkg::t_status status;
    } t_decide;

    logic [PW-1:0]     r_pos,   n_pos,   s_pos;
    t_phase            r_phase, n_phase, s_phase;
    logic [15:0]       r_cur,   n_cur,   s_cur;
    logic [23:0]       r_gather;
    logic [3:0]        r_cnt,   n_cnt,   s_cnt;
    logic [1:0]        r_tags,  n_tags,  s_tags;
    logic [11:0]       r_id     [2];
    logic [11:0]       n_id     [2];
    logic [11:0]       s_id     [2];
    logic [15:0]       r_ttype  [2];
    logic [15:0]       n_ttype  [2];
    logic [15:0]       s_ttype  [2];
    elhp_pkg::t_status r_dec,   n_dec,   s_dec;
    logic [8:0]        r_hend,  n_hend,  s_hend;

    logic [31:0]       word;
    logic [3:0]        cnt_inc;
    logic [8:0]        hend_inc;
    t_decide           dcd;
    logic              do_decide;
    logic [15:0]       dcd_type;
    logic [8:0]        dcd_hend;
    logic [1:0]        dcd_tags;
    elhp_pkg::t_status res_status;
    logic [DW-1:0]     len_diff;

    // examine an ethertype at the current header end
    function automatic t_decide decide(input logic [15:0] typ, input logic [8:0] hend,
                                       input logic [1:0] tags, input logic [7:0] limit);
        t_decide d;
        d.phase  = PH_DONE;
        d.status = elhp_pkg::ST_TRUNC;
        if (typ == elhp_pkg::ET_IPV4) begin
            d.status = elhp_pkg::ST_IPV4;
        end else if (typ == elhp_pkg::ET_IPV6) begin
            d.status = elhp_pkg::ST_IPV6;
        end else if (hend > {1'b0, limit}) begin
            d.status = elhp_pkg::ST_NOIP;
        end else if (typ == elhp_pkg::ET_VLAN || typ == elhp_pkg::ET_QINQ1 ||
                     typ == elhp_pkg::ET_QINQ2 || typ == elhp_pkg::ET_QINQ3) begin
            if (tags >= 2'(MAX_TAGS)) begin
                d.status = elhp_pkg::ST_TOOMANY;
            end else begin
                d.phase = PH_TAG;
            end
        end else if (typ == elhp_pkg::ET_MPLS_U || typ == elhp_pkg::ET_MPLS_M) begin
            d.phase = PH_LABEL;
        end else begin
            d.status = elhp_pkg::ST_UNSUPP;
        end
        return d;
    endfunction

    assign word     = {r_gather, i_byte};
    assign cnt_inc  = r_cnt + 4'd1;
    assign hend_inc = r_hend + elhp_pkg::WORD_STEP;

    // operands of the type decision for this byte
    always_comb begin
        do_decide = 1'b0;
        dcd_type  = r_cur;
        dcd_hend  = r_hend;
        dcd_tags  = r_tags;
        unique case (r_phase)
            PH_TYPE: begin
                if (cnt_inc >= elhp_pkg::TYPE_BYTES) begin
                    do_decide = 1'b1;
                    dcd_type  = word[15:0];
                    dcd_hend  = elhp_pkg::L2_BASE;
                end
            end
            PH_TAG: begin
                if (cnt_inc >= elhp_pkg::WORD_BYTES) begin
                    do_decide = 1'b1;
                    dcd_type  = word[15:0];
                    dcd_hend  = hend_inc;
                    dcd_tags  = r_tags + 2'd1;
                end
            end
            PH_LABEL: begin
                // bottom of stack, or label walk past its limit: take as ipv4
                if (cnt_inc >= elhp_pkg::WORD_BYTES &&
                    (word[8] || hend_inc > {1'b0, i_cfg.label_limit})) begin
                    do_decide = 1'b1;
                    dcd_type  = elhp_pkg::ET_IPV4;
                    dcd_hend  = hend_inc;
                end
            end
            PH_MAC, PH_DONE: begin
                do_decide = 1'b0;
            end
            default: begin
                do_decide = 1'b0;
            end
        endcase
    end

    assign dcd = decide(dcd_type, dcd_hend, dcd_tags, i_cfg.header_limit);

    // state after taking this byte
    always_comb begin
        s_pos   = (r_pos < POS_MAX) ? r_pos + PW'(1) : r_pos;
        s_phase = r_phase;
        s_cur   = r_cur;
        s_cnt   = r_cnt;
        s_tags  = r_tags;
        s_id    = r_id;
        s_ttype = r_ttype;
        s_dec   = r_dec;
        s_hend  = r_hend;
        unique case (r_phase)
            PH_MAC: begin
                if (cnt_inc >= elhp_pkg::MAC_BYTES) begin
                    s_cnt   = '0;
                    s_phase = PH_TYPE;
                end else begin
                    s_cnt = cnt_inc;
                end
            end
            PH_TYPE: begin
                s_cnt = cnt_inc;
            end
            PH_TAG: begin
                s_cnt = cnt_inc;
                if (cnt_inc >= elhp_pkg::WORD_BYTES) begin
                    s_id[r_tags[0]]    = word[27:16];
                    s_ttype[r_tags[0]] = r_cur;
                    s_tags             = dcd_tags;
                end
            end
            PH_LABEL: begin
                if (cnt_inc >= elhp_pkg::WORD_BYTES) begin
                    s_cnt  = '0;
                    s_hend = hend_inc;
                end else begin
                    s_cnt = cnt_inc;
                end
            end
            PH_DONE: begin
                s_cnt = r_cnt;
            end
            default: begin
                s_cnt = r_cnt;
            end
        endcase
        if (do_decide) begin
            s_cur   = dcd_type;
            s_hend  = dcd_hend;
            s_cnt   = '0;
            s_phase = dcd.phase;
            s_dec   = dcd.status;
        end
    end

    // result of the frame ending on this byte
    assign res_status = (s_phase == PH_DONE) ? s_dec : elhp_pkg::ST_TRUNC;
    assign len_diff   = DW'(s_pos) - DW'(s_hend);

    always_comb begin
        o_result.status         = res_status;
        o_result.l3_offset      = '0;
        o_result.l3_length      = '0;
        o_result.tag_count      = s_tags;
        o_result.outer_vlan_id  = s_id[0];
        o_result.inner_vlan_id  = s_id[1];
        o_result.outer_tag_type = s_ttype[0];
        o_result.inner_tag_type = s_ttype[1];
        if (res_status != elhp_pkg::ST_TRUNC) begin
            o_result.l3_offset = s_hend[8] ? 8'hFF : s_hend[7:0];
        end
        if ((res_status == elhp_pkg::ST_IPV4 || res_status == elhp_pkg::ST_IPV6) &&
            DW'(s_pos) >= DW'(s_hend)) begin
            o_result.l3_length = (len_diff > DW'(elhp_pkg::LEN_SAT)) ? elhp_pkg::LEN_SAT
                                                                     : len_diff[13:0];
        end
    end

    assign o_result_valid = i_step && i_last;

    // next state: hold, step, or clear after the last byte
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_cur   = r_cur;
        n_cnt   = r_cnt;
        n_tags  = r_tags;
        n_id    = r_id;
        n_ttype = r_ttype;
        n_dec   = r_dec;
        n_hend  = r_hend;
        if (i_step) begin
            if (i_last) begin
                n_pos      = '0;
                n_phase    = PH_MAC;
                n_cur      = '0;
                n_cnt      = '0;
                n_tags     = '0;
                n_id[0]    = '0;
                n_id[1]    = '0;
                n_ttype[0] = '0;
                n_ttype[1] = '0;
                n_dec      = elhp_pkg::ST_TRUNC;
                n_hend     = '0;
            end else begin
                n_pos   = s_pos;
                n_phase = s_phase;
                n_cur   = s_cur;
                n_cnt   = s_cnt;
                n_tags  = s_tags;
                n_id    = s_id;
                n_ttype = s_ttype;
                n_dec   = s_dec;
                n_hend  = s_hend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= PH_MAC;
            r_cur      <= '0;
            r_cnt      <= '0;
            r_tags     <= '0;
            r_id[0]    <= '0;
            r_id[1]    <= '0;
            r_ttype[0] <= '0;
            r_ttype[1] <= '0;
            r_dec      <= elhp_pkg::ST_TRUNC;
            r_hend     <= '0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_cnt   <= n_cnt;
            r_tags  <= n_tags;
            r_id    <= n_id;
            r_ttype <= n_ttype;
            r_dec   <= n_dec;
            r_hend  <= n_hend;
        end
    end

    // last three bytes, only ever read within a counted word
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_gather <= word[23:0];
        end
    end

endmodule

FILE: rtl/ethernet_l2_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_l2_header_parser
// byte-serial ethernet header parser: vlan/qinq tags, mpls labels, l3 offset
// ----------------------------------------------------------------------------
//  channel   direction  signals                          word contents
//  s_axis    in         tvalid tready tdata[7:0] tlast   frame byte, tlast on final byte
//  m_axis    out        tvalid tready tdata[79:0] tuser  one parse result per frame
//  cfg       in         i_cfg_we i_cfg_addr i_cfg_data   0 header_limit, 1 label_limit
//
//  one byte per cycle unless a result waits on a stalled receiver: the input register feeds
//  the parse state directly, and the byte-wide next-state logic is combinational
//  a result enters the output register as the final byte leaves the input register
//  s_axis is only held off while a result sits unread in the output register
//  synchronous active-low reset clears the parse state and loads the default limits
// ----------------------------------------------------------------------------
module ethernet_l2_header_parser #(
    parameter int MAX_FRAME_BYTES = 16384,
    parameter int MAX_TAGS        = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // frame bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  logic        s_axis_tlast,   // last_byte
    // parse results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] l3_offset, [21:8] l3_length, [23:22] tag_count, [35:24] outer_vlan_id,
    // [47:36] inner_vlan_id, [63:48] outer_tag_type, [79:64] inner_tag_type
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    elhp_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    elhp_pkg::t_result r_out;

    logic              step;
    logic              res_valid;
    elhp_pkg::t_result res;

    // input word moves into the parser when a result slot is free
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_limit <= elhp_pkg::HEADER_LIMIT_RST;
            r_cfg.label_limit  <= elhp_pkg::LABEL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                elhp_pkg::CFG_HEADER_LIMIT: r_cfg.header_limit <= i_cfg_data;
                elhp_pkg::CFG_LABEL_LIMIT:  r_cfg.label_limit  <= i_cfg_data;
                default:                    r_cfg <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    elhp_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MAX_TAGS        (MAX_TAGS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_cfg          (r_cfg),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {r_out.inner_tag_type, r_out.outer_tag_type,
                            r_out.inner_vlan_id, r_out.outer_vlan_id,
                            r_out.tag_count, r_out.l3_length, r_out.l3_offset};

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte-serial layer-2 header parser: frames are
// built byte by byte, a behavioral parser in the bench predicts each result,
// and every result word on m_axis is compared field by field in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_LEN       = 16384;  // frame length counter saturates here
    localparam int TAG_SLOTS     = 2;
    localparam int RANDOM_BYTES  = 800;
    localparam int RANDOM_FRAMES = 20;

    // parse progress of the behavioral parser
    typedef enum logic [2:0] {
        WALK_MAC,
        WALK_TYPE,
        WALK_TAG,
        WALK_LABEL,
        WALK_DONE
    } t_walk;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = 1'b0;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] frame_byte
    logic        s_axis_tlast  = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] l3_offset, [21:8] l3_length, [23:22] tag_count, [35:24] outer_vlan_id,
    // [47:36] inner_vlan_id, [63:48] outer_tag_type, [79:64] inner_tag_type
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;           // [2:0] status

    ethernet_l2_header_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // behavioral parser state, a private copy of what the block keeps per frame
    t_walk             walk;
    int                frame_len;
    logic [15:0]       cur_type;
    logic [31:0]       gather;
    int                gathered;
    int                tags_read;
    logic [11:0]       tag_id [TAG_SLOTS];
    logic [15:0]       tag_et [TAG_SLOTS];
    elhp_pkg::t_status verdict;
    int                hdr_end;

    // limits as last written to the block
    int lim_header = int'(elhp_pkg::HEADER_LIMIT_RST);
    int lim_label  = int'(elhp_pkg::LABEL_LIMIT_RST);

    // results predicted but not yet seen on m_axis, oldest first
    elhp_pkg::t_result pending_results[$];

    // frame under construction
    logic [7:0] frame[$];

    // idle and stall odds in percent per cycle
    int idle_pct  = 0;
    int stall_pct = 0;

    int cycles        = 0;
    int mismatches    = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int results_seen  = 0;
    int status_seen [6];

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // behavioral parser
    // ------------------------------------------------------------------------
    function automatic void clear_parse();
        walk      = WALK_MAC;
        frame_len = 0;
        cur_type  = '0;
        gather    = '0;
        gathered  = 0;
        tags_read = 0;
        tag_id[0] = '0;
        tag_id[1] = '0;
        tag_et[0] = '0;
        tag_et[1] = '0;
        verdict   = elhp_pkg::ST_TRUNC;
        hdr_end   = 0;
    endfunction

    // look at cur_type sitting at hdr_end and pick the next step
    function automatic void classify_type();
        gather   = '0;
        gathered = 0;
        if (cur_type == elhp_pkg::ET_IPV4) begin
            verdict = elhp_pkg::ST_IPV4;
            walk    = WALK_DONE;
        end else if (cur_type == elhp_pkg::ET_IPV6) begin
            verdict = elhp_pkg::ST_IPV6;
            walk    = WALK_DONE;
        end else if (hdr_end > lim_header) begin
            // ip check comes first, so a late ip type still wins over the limit
            verdict = elhp_pkg::ST_NOIP;
            walk    = WALK_DONE;
        end else if (cur_type inside {elhp_pkg::ET_VLAN, elhp_pkg::ET_QINQ1,
                                      elhp_pkg::ET_QINQ2, elhp_pkg::ET_QINQ3}) begin
            if (tags_read >= TAG_SLOTS) begin
                verdict = elhp_pkg::ST_TOOMANY;
                walk    = WALK_DONE;
            end else begin
                walk = WALK_TAG;
            end
        end else if (cur_type == elhp_pkg::ET_MPLS_U || cur_type == elhp_pkg::ET_MPLS_M) begin
            walk = WALK_LABEL;
        end else begin
            verdict = elhp_pkg::ST_UNSUPP;
            walk    = WALK_DONE;
        end
    endfunction

    // advance by one accepted byte; the final byte of a frame queues a result
    function automatic void parse_byte(input logic [7:0] b, input logic lst);
        elhp_pkg::t_result r;
        elhp_pkg::t_status st;
        int                n;
        int                len;
        if (frame_len < MAX_LEN)
            frame_len++;
        unique case (walk)
            WALK_MAC: begin
                gathered++;
                if (gathered >= 12) begin
                    gathered = 0;
                    gather   = '0;
                    walk     = WALK_TYPE;
                end
            end
            WALK_TYPE: begin
                gather = {gather[23:0], b};
                gathered++;
                if (gathered >= 2) begin
                    cur_type = gather[15:0];
                    hdr_end  = 14;
                    classify_type();
                end
            end
            WALK_TAG: begin
                // tci in the upper half, the next ethertype in the lower half
                gather = {gather[23:0], b};
                gathered++;
                if (gathered >= 4) begin
                    n         = tags_read % 2;
                    tag_id[n] = gather[27:16];
                    tag_et[n] = cur_type;
                    tags_read++;
                    cur_type  = gather[15:0];
                    hdr_end  += 4;
                    classify_type();
                end
            end
            WALK_LABEL: begin
                gather = {gather[23:0], b};
                gathered++;
                if (gathered >= 4) begin
                    hdr_end += 4;
                    gathered = 0;
                    // bottom of stack, or the label walk ran past its limit
                    if (gather[8] || hdr_end > lim_label) begin
                        cur_type = elhp_pkg::ET_IPV4;
                        classify_type();
                    end else begin
                        gather = '0;
                    end
                end
            end
            default: ;
        endcase

        if (lst) begin
            st       = (walk == WALK_DONE) ? verdict : elhp_pkg::ST_TRUNC;
            r        = '0;
            r.status = st;
            if (st != elhp_pkg::ST_TRUNC)
                r.l3_offset = (hdr_end > 255) ? 8'd255 : 8'(hdr_end);
            if ((st == elhp_pkg::ST_IPV4 || st == elhp_pkg::ST_IPV6) && frame_len >= hdr_end) begin
                len = frame_len - hdr_end;
                if (len > 16383)
                    len = 16383;
                r.l3_length = 14'(len);
            end
            r.tag_count      = 2'(tags_read);
            r.outer_vlan_id  = tag_id[0];
            r.inner_vlan_id  = tag_id[1];
            r.outer_tag_type = tag_et[0];
            r.inner_tag_type = tag_et[1];
            pending_results.push_back(r);
            clear_parse();
        end
    endfunction

    initial clear_parse();

    // ------------------------------------------------------------------------
    // frame building
    // ------------------------------------------------------------------------
    function automatic void put_mac();
        repeat (12) frame.push_back(8'($urandom));
    endfunction

    function automatic void put16(input logic [15:0] v);
        frame.push_back(v[15:8]);
        frame.push_back(v[7:0]);
    endfunction

    function automatic void put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    // one mpls label, bottom-of-stack bit chosen by the caller
    function automatic void put_label(input logic bottom);
        logic [31:0] label;
        label    = $urandom;
        label[8] = bottom;
        put32(label);
    endfunction

    function automatic void put_payload(input int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    function automatic void trim_frame(input int keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endfunction

    function automatic logic [15:0] pick_tag_type();
        unique case ($urandom_range(3))
            0:       return elhp_pkg::ET_VLAN;
            1:       return elhp_pkg::ET_QINQ1;
            2:       return elhp_pkg::ET_QINQ2;
            default: return elhp_pkg::ET_QINQ3;
        endcase
    endfunction

    function automatic logic [7:0] pick_limit();
        unique case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd13;
            2:       return 8'd14;
            3:       return 8'd255;
            default: return 8'($urandom_range(14, 255));
        endcase
    endfunction

    // mostly well-formed headers with random content, some noise and cut frames
    function automatic void gen_random_frame();
        int ntags;
        int kind;
        int nlabels;
        frame.delete();
        if ($urandom_range(19) == 0) begin
            put_payload($urandom_range(1, 40));
        end else begin
            put_mac();
            ntags = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3);
            repeat (ntags) begin
                put16(pick_tag_type());
                put16(16'($urandom));
            end
            kind = $urandom_range(99);
            if (kind < 35) begin
                put16(elhp_pkg::ET_IPV4);
            end else if (kind < 55) begin
                put16(elhp_pkg::ET_IPV6);
            end else if (kind < 80) begin
                put16($urandom_range(1) ? elhp_pkg::ET_MPLS_U : elhp_pkg::ET_MPLS_M);
                nlabels = $urandom_range(1, 5);
                for (int i = 0; i < nlabels; i++)
                    put_label(i == nlabels - 1 && $urandom_range(4) != 0);
            end else if (kind < 92) begin
                put16(16'($urandom));
            end else begin
                put16(pick_tag_type());
            end
            put_payload($urandom_range(0, 40));
            if ($urandom_range(9) == 0)
                trim_frame($urandom_range(1, frame.size()));
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // one frame byte; valid stays high afterwards so back-to-back bytes flow
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        parse_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    // stop sending and let every outstanding result come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // limits change only with the parser idle
    task automatic write_limit(input logic addr, input logic [7:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == elhp_pkg::CFG_HEADER_LIMIT)
            lim_header = int'(value);
        else
            lim_label = int'(value);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("error at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // receiver stalls at random with the odds of the current phase
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin : check_results
        elhp_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser <= elhp_pkg::ST_TRUNC)
                status_seen[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with no frame outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("status", int'(m_axis_tuser), int'(want.status));
                check_field("l3_offset", int'(m_axis_tdata[7:0]), int'(want.l3_offset));
                check_field("l3_length", int'(m_axis_tdata[21:8]), int'(want.l3_length));
                check_field("tag_count", int'(m_axis_tdata[23:22]), int'(want.tag_count));
                check_field("outer_vlan_id", int'(m_axis_tdata[35:24]),
                            int'(want.outer_vlan_id));
                check_field("inner_vlan_id", int'(m_axis_tdata[47:36]),
                            int'(want.inner_vlan_id));
                check_field("outer_tag_type", int'(m_axis_tdata[63:48]),
                            int'(want.outer_tag_type));
                check_field("inner_tag_type", int'(m_axis_tdata[79:64]),
                            int'(want.inner_tag_type));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // ipv4, ipv6, too-many and unsupported statuses under the reset limits, plus all-zero and all-one bytes
    task automatic test_status_codes();
        frame.delete();
        repeat (12) frame.push_back(8'h00);
        put16(elhp_pkg::ET_IPV4);
        put_payload(20);
        send_frame();

        frame.delete();
        repeat (12) frame.push_back(8'hFF);
        put16(elhp_pkg::ET_IPV6);
        repeat (40) frame.push_back(8'hFF);
        send_frame();

        // single vlan tag, id all ones
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_VLAN);
        put16(16'hFFFF);
        put16(elhp_pkg::ET_IPV4);
        put_payload(8);
        send_frame();

        // qinq pair, outer id zero
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_QINQ1);
        put16(16'hF000);
        put16(elhp_pkg::ET_VLAN);
        put16(16'h0ABC);
        put16(elhp_pkg::ET_IPV6);
        put_payload(12);
        send_frame();

        // third tag is one too many
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_QINQ2);
        put16(16'h1234);
        put16(elhp_pkg::ET_QINQ3);
        put16(16'h5678);
        put16(elhp_pkg::ET_VLAN);
        put16(16'h9ABC);
        put_payload(6);
        send_frame();

        // arp is not handled
        frame.delete();
        put_mac();
        put16(16'h0806);
        put_payload(28);
        send_frame();

        // mpls unicast, bottom on the second label
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_MPLS_U);
        put_label(1'b0);
        put_label(1'b1);
        put_payload(20);
        send_frame();

        // mpls multicast, single label
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_MPLS_M);
        put_label(1'b1);
        put_payload(4);
        send_frame();

        // header ends exactly at the last byte
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_IPV4);
        send_frame();
    endtask

    // last byte arrives before a decision
    task automatic test_truncated_frames();
        frame.delete();
        frame.push_back(8'h5A);
        send_frame();

        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_IPV4);
        trim_frame(13);
        send_frame();

        // cut inside the first tag
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_VLAN);
        put16(16'h0123);
        send_frame();

        // first tag complete, cut inside the second
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_QINQ1);
        put16(16'h0456);
        put16(elhp_pkg::ET_VLAN);
        put16(16'h0789);
        send_frame();

        // cut inside a label
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_MPLS_U);
        put_label(1'b0);
        put16(16'h0001);
        send_frame();
    endtask

    // header and label limits at and below their extremes
    task automatic test_limits();
        // header limit below the first type offset: tags give up at once
        write_limit(elhp_pkg::CFG_HEADER_LIMIT, 8'd13);
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_VLAN);
        put16(16'h0111);
        put16(elhp_pkg::ET_IPV4);
        put_payload(4);
        send_frame();
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_IPV4);
        put_payload(4);
        send_frame();

        write_limit(elhp_pkg::CFG_HEADER_LIMIT, 8'd0);
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_IPV6);
        put_payload(4);
        send_frame();

        // one tag fits, the type after it lies beyond the limit
        write_limit(elhp_pkg::CFG_HEADER_LIMIT, 8'd14);
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_VLAN);
        put16(16'h0222);
        put16(elhp_pkg::ET_VLAN);
        put16(16'h0333);
        put_payload(4);
        send_frame();

        // first label already past the label limit: taken as ipv4 without bottom
        write_limit(elhp_pkg::CFG_HEADER_LIMIT, 8'd255);
        write_limit(elhp_pkg::CFG_LABEL_LIMIT, 8'd14);
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_MPLS_U);
        put_label(1'b0);
        put_payload(10);
        send_frame();

        // long stack with no bottom: offset saturates at 255
        write_limit(elhp_pkg::CFG_LABEL_LIMIT, 8'd255);
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_MPLS_M);
        repeat (62) put_label(1'b0);
        put_payload(6);
        send_frame();

        write_limit(elhp_pkg::CFG_LABEL_LIMIT, 8'd0);
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_MPLS_U);
        put_label(1'b0);
        put_label(1'b1);
        send_frame();

        write_limit(elhp_pkg::CFG_HEADER_LIMIT, elhp_pkg::HEADER_LIMIT_RST);
        write_limit(elhp_pkg::CFG_LABEL_LIMIT, elhp_pkg::LABEL_LIMIT_RST);
    endtask

    // long frame: layer-3 length needs more than eight bits
    task automatic test_long_frame();
        frame.delete();
        put_mac();
        put16(elhp_pkg::ET_IPV4);
        put_payload(260);
        send_frame();
    endtask

    // random frames in phases of idling and receiver stalls, limits re-drawn per phase
    task automatic test_random_frames();
        int blk;
        int byte_base;
        int frame_base;
        blk        = 0;
        byte_base  = bytes_sent;
        frame_base = frames_sent;
        while (bytes_sent - byte_base < RANDOM_BYTES
               || frames_sent - frame_base < RANDOM_FRAMES) begin
            write_limit(elhp_pkg::CFG_HEADER_LIMIT, pick_limit());
            write_limit(elhp_pkg::CFG_LABEL_LIMIT, pick_limit());
            unique case (blk % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            repeat (5) begin
                gen_random_frame();
                send_frame();
            end
            blk++;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_status_codes();
        test_truncated_frames();
        test_limits();
        test_long_frame();
        test_random_frames();

        drain();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) @(posedge i_clk);

        $display("%0d frames in %0d bytes sent, %0d result words checked, %0d errors",
                 frames_sent, bytes_sent, results_seen, mismatches);
        $display("status mix: ipv4 %0d ipv6 %0d too-many %0d unsupported %0d no-ip %0d trunc %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
